>>> src/cda_pkg.sv
`default_nettype none

package cda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 16;
    localparam int DNUM_W  = 22;
    localparam int ACT_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [YEAR_W-1:0]  MAX_YEAR      = 14'd9999;
    localparam logic [YEAR_W-1:0]  FALLBACK_YEAR = 14'd1900;
    localparam logic [YEAR_W-1:0]  RESET_LOW     = 14'd1900;
    localparam logic [YEAR_W-1:0]  RESET_HIGH    = 14'd2030;
    // Day number of 9999-12-31, counted from 0000-01-01.
    localparam logic [DNUM_W-1:0]  LAST_DAY      = 22'd3652424;

    localparam logic [ACT_W-1:0] ACT_LOAD     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_PRE_INC  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_POST_INC = 4'd2;
    localparam logic [ACT_W-1:0] ACT_PRE_DEC  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_POST_DEC = 4'd4;
    localparam logic [ACT_W-1:0] ACT_ADD      = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SUB      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LESS     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_DIST     = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_YEAR_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YEAR_HIGH = 2'd1;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [YEAR_W-1:0]  operand_year;
        logic [MONTH_W-1:0] operand_month;
        logic [DAY_W-1:0]   operand_day;
        logic [CNT_W-1:0]   day_count;
    } op_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [DAY_W-1:0]   result_day;
        logic               is_earlier;
        logic [DNUM_W-1:0]  day_distance;
        logic               range_error;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NOW,
        S_OTHER,
        S_EVAL,
        S_SMID,
        S_SCMP,
        S_MONTH,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic now;
        logic other;
        logic eval;
        logic smid;
        logic scmp;
        logic month;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search;
        logic search_done;
    } sts_t;

    // Floor of x / 100 by a reciprocal multiply, exact for x below 16384.
    function automatic logic [8:0] div100(input logic [14:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'd5243;
        return prod[27:19];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [8:0]  q;
        logic [14:0] r;
        q = div100({1'b0, y});
        r = {1'b0, y} - 15'(q) * 15'd100;
        return ((y[1:0] == 2'd0) && (r != 15'd0)) || ((r == 15'd0) && (q[1:0] == 2'd0));
    endfunction

    // Days from 0000-01-01 to the first day of year y.
    function automatic logic [DNUM_W-1:0] year_start(input logic [YEAR_W-1:0] y);
        logic [14:0] a4;
        logic [14:0] a100;
        logic [14:0] a400;
        logic [8:0]  q100;
        logic [8:0]  q400;
        a4   = {1'b0, y} + 15'd3;
        a100 = {1'b0, y} + 15'd99;
        a400 = {1'b0, y} + 15'd399;
        q100 = div100(a100);
        q400 = div100({2'b00, a400[14:2]});
        return 22'(y) * 22'd365 + 22'(a4[14:2]) - 22'(q100) + 22'(q400);
    endfunction

    // Days of the year before the first of month m; months above 12 count the whole year.
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m, input logic lp);
        logic [8:0] c;
        case (m)
            4'd0, 4'd1: c = 9'd0;
            4'd2:  c = 9'd31;
            4'd3:  c = 9'd59;
            4'd4:  c = 9'd90;
            4'd5:  c = 9'd120;
            4'd6:  c = 9'd151;
            4'd7:  c = 9'd181;
            4'd8:  c = 9'd212;
            4'd9:  c = 9'd243;
            4'd10: c = 9'd273;
            4'd11: c = 9'd304;
            4'd12: c = 9'd334;
            default: c = 9'd365;
        endcase
        return c + 9'((lp && (m >= 4'd3)) ? 1 : 0);
    endfunction

    function automatic logic [DAY_W-1:0] days_of_month(input logic [MONTH_W-1:0] m,
                                                       input logic lp);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2: n = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic date_exists(input logic [YEAR_W-1:0] y,
                                         input logic [MONTH_W-1:0] m,
                                         input logic [DAY_W-1:0] d);
        return (y <= MAX_YEAR) && (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1)
            && (d <= days_of_month(m, is_leap(y)));
    endfunction

endpackage

`default_nettype wire

>>> src/cda_ctrl.sv
`default_nettype none

module cda_ctrl
    import cda_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      done
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one transaction and the commands for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_NOW;
                end
            end
            S_NOW:
            begin
                cmd.now    = 1'b1;
                state_next = S_OTHER;
            end
            S_OTHER:
            begin
                cmd.other  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.search ? S_SMID : S_DONE;
            end
            S_SMID:
            begin
                cmd.smid   = 1'b1;
                state_next = sts.search_done ? S_MONTH : S_SCMP;
            end
            S_SCMP:
            begin
                cmd.scmp   = 1'b1;
                state_next = S_SMID;
            end
            S_MONTH:
            begin
                cmd.month  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

>>> src/cda_datapath.sv
`default_nettype none

module cda_datapath
    import cda_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    input  wire op_t                  operand,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [YEAR_W-1:0]    cfg_data,
    output sts_t                      sts,
    output res_t                      result
);

    logic [YEAR_W-1:0]  low_reg;
    logic [YEAR_W-1:0]  high_reg;
    logic [YEAR_W-1:0]  cur_year_reg;
    logic [MONTH_W-1:0] cur_month_reg;
    logic [DAY_W-1:0]   cur_day_reg;
    op_t                op_reg;
    logic [DNUM_W-1:0]  now_reg;
    logic [DNUM_W-1:0]  other_reg;
    logic [DNUM_W-1:0]  target_reg;
    logic [YEAR_W-1:0]  lo_reg;
    logic [YEAR_W-1:0]  hi_reg;
    logic [YEAR_W-1:0]  mid_reg;
    logic [DNUM_W-1:0]  ys_reg;
    logic               upd_cur_reg;
    logic               upd_res_reg;
    res_t               res_reg;

    // Shared year start unit; its year comes from the step in progress.
    logic [YEAR_W-1:0]  ys_year;
    logic [DNUM_W-1:0]  ys_val;
    logic [YEAR_W:0]    mid_sum;
    logic [DNUM_W-1:0]  dnum;

    // Evaluation of the action once both day numbers are known.
    logic               ev_search;
    logic [DNUM_W-1:0]  ev_target;
    logic               ev_upd_cur;
    logic               ev_upd_res;
    logic               ev_load_ok;
    res_t               ev_res;
    logic [DNUM_W:0]    add_sum;

    // Splitting the remainder of the year into month and day.
    logic               fin_leap;
    logic [8:0]         fin_rem;
    logic [MONTH_W-1:0] fin_month;
    logic [DAY_W-1:0]   fin_day;

    assign mid_sum = ({1'b0, lo_reg} + {1'b0, hi_reg} + 15'd1) >> 1;

    always_comb
    begin
        if (cmd.smid)
        begin
            ys_year = mid_sum[YEAR_W-1:0];
        end
        else if (cmd.other)
        begin
            ys_year = op_reg.operand_year;
        end
        else
        begin
            ys_year = cur_year_reg;
        end
    end

    assign ys_val = year_start(ys_year);

    // Day number of the date chosen for this step.
    always_comb
    begin
        if (cmd.other)
        begin
            dnum = ys_val + 22'(cum_days(op_reg.operand_month, is_leap(ys_year)))
                 + 22'(op_reg.operand_day) - 22'd1;
        end
        else
        begin
            dnum = ys_val + 22'(cum_days(cur_month_reg, is_leap(ys_year)))
                 + 22'(cur_day_reg) - 22'd1;
        end
    end

    assign add_sum = {1'b0, now_reg} + 23'(op_reg.day_count);

    always_comb
    begin
        ev_search  = 1'b0;
        ev_target  = now_reg;
        ev_upd_cur = 1'b0;
        ev_upd_res = 1'b0;
        ev_load_ok = (op_reg.operand_year >= low_reg) && (op_reg.operand_year <= high_reg)
                   && date_exists(op_reg.operand_year, op_reg.operand_month,
                                  op_reg.operand_day);
        ev_res     = '0;
        ev_res.result_year  = cur_year_reg;
        ev_res.result_month = cur_month_reg;
        ev_res.result_day   = cur_day_reg;
        case (op_reg.action)
            ACT_LOAD:
            begin
                if (ev_load_ok)
                begin
                    ev_res.result_year  = op_reg.operand_year;
                    ev_res.result_month = op_reg.operand_month;
                    ev_res.result_day   = op_reg.operand_day;
                end
                else
                begin
                    ev_res.result_year  = FALLBACK_YEAR;
                    ev_res.result_month = 4'd1;
                    ev_res.result_day   = 5'd1;
                end
            end
            ACT_PRE_INC, ACT_POST_INC:
            begin
                if (now_reg >= LAST_DAY)
                begin
                    ev_res.range_error = 1'b1;
                end
                else
                begin
                    ev_search  = 1'b1;
                    ev_target  = now_reg + 22'd1;
                    ev_upd_cur = 1'b1;
                    ev_upd_res = (op_reg.action == ACT_PRE_INC);
                end
            end
            ACT_PRE_DEC, ACT_POST_DEC:
            begin
                if (now_reg == '0)
                begin
                    ev_res.range_error = 1'b1;
                end
                else
                begin
                    ev_search  = 1'b1;
                    ev_target  = now_reg - 22'd1;
                    ev_upd_cur = 1'b1;
                    ev_upd_res = (op_reg.action == ACT_PRE_DEC);
                end
            end
            ACT_ADD:
            begin
                if (add_sum > {1'b0, LAST_DAY})
                begin
                    ev_res.range_error = 1'b1;
                end
                else
                begin
                    ev_search  = 1'b1;
                    ev_target  = add_sum[DNUM_W-1:0];
                    ev_upd_res = 1'b1;
                end
            end
            ACT_SUB:
            begin
                if (22'(op_reg.day_count) > now_reg)
                begin
                    ev_res.range_error = 1'b1;
                end
                else
                begin
                    ev_search  = 1'b1;
                    ev_target  = now_reg - 22'(op_reg.day_count);
                    ev_upd_res = 1'b1;
                end
            end
            ACT_LESS:
            begin
                if (cur_year_reg != op_reg.operand_year)
                begin
                    ev_res.is_earlier = (cur_year_reg < op_reg.operand_year);
                end
                else if (cur_month_reg != op_reg.operand_month)
                begin
                    ev_res.is_earlier = (cur_month_reg < op_reg.operand_month);
                end
                else
                begin
                    ev_res.is_earlier = (cur_day_reg < op_reg.operand_day);
                end
            end
            ACT_DIST:
            begin
                if (!date_exists(op_reg.operand_year, op_reg.operand_month,
                                 op_reg.operand_day))
                begin
                    ev_res.range_error = 1'b1;
                end
                else if (now_reg > other_reg)
                begin
                    ev_res.day_distance = now_reg - other_reg;
                end
                else
                begin
                    ev_res.day_distance = other_reg - now_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Month and day from the day offset within the found year.
    assign fin_leap = is_leap(lo_reg);
    assign fin_rem  = 9'(target_reg - ys_reg);

    always_comb
    begin
        fin_month = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (cum_days(MONTH_W'(k), fin_leap) <= fin_rem)
            begin
                fin_month = MONTH_W'(k);
            end
        end
        fin_day = 5'(fin_rem - cum_days(fin_month, fin_leap) + 9'd1);
    end

    assign sts.search      = ev_search;
    assign sts.search_done = (lo_reg == hi_reg);
    assign result          = res_reg;

    // Configuration registers and the stored date.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= RESET_LOW;
            high_reg      <= RESET_HIGH;
            cur_year_reg  <= FALLBACK_YEAR;
            cur_month_reg <= 4'd1;
            cur_day_reg   <= 5'd1;
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_YEAR_LOW))
            begin
                low_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_YEAR_HIGH))
            begin
                high_reg <= cfg_data;
            end
            if (cmd.eval && (op_reg.action == ACT_LOAD))
            begin
                cur_year_reg  <= ev_res.result_year;
                cur_month_reg <= ev_res.result_month;
                cur_day_reg   <= ev_res.result_day;
            end
            else if (cmd.month && upd_cur_reg)
            begin
                cur_year_reg  <= lo_reg;
                cur_month_reg <= fin_month;
                cur_day_reg   <= fin_day;
            end
        end
    end

    // Working registers of one transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= operand;
        end
        if (cmd.now)
        begin
            now_reg <= dnum;
        end
        if (cmd.other)
        begin
            other_reg <= dnum;
        end
        if (cmd.eval)
        begin
            res_reg     <= ev_res;
            target_reg  <= ev_target;
            upd_cur_reg <= ev_upd_cur;
            upd_res_reg <= ev_upd_res;
            lo_reg      <= '0;
            hi_reg      <= MAX_YEAR;
        end
        if (cmd.smid)
        begin
            mid_reg <= mid_sum[YEAR_W-1:0];
            ys_reg  <= ys_val;
        end
        if (cmd.scmp)
        begin
            if (ys_reg <= target_reg)
            begin
                lo_reg <= mid_reg;
            end
            else
            begin
                hi_reg <= mid_reg - 14'd1;
            end
        end
        if (cmd.month && upd_res_reg)
        begin
            res_reg.result_year  <= lo_reg;
            res_reg.result_month <= fin_month;
            res_reg.result_day   <= fin_day;
        end
    end

endmodule

`default_nettype wire

>>> src/calendar_date_arithmetic_unit.sv
`default_nettype none

// Gregorian date counter with one stored date. An action is taken when start is high and
// busy is low; its single result is marked by result_valid for exactly one cycle, and
// must be captured then. Load, compare, distance and any action that ends in a range error
// go from evaluation straight to the result; steps, add and subtract first find the year by
// a binary search of at most 14 rounds, each using the one shared year start unit, and then
// split the rest of the year into month and day. Configuration writes are always accepted.
module calendar_date_arithmetic_unit
    import cda_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire op_t                  operand,
    output res_t                      result,
    output logic                      result_valid,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [YEAR_W-1:0]    cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic ctrl_busy;

    assign cfg_ready = 1'b1;
    assign busy      = ctrl_busy;

    // Sequencer.
    cda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (ctrl_busy),
        .done  (result_valid)
    );

    // Date arithmetic and stored date.
    cda_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operand   (operand),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> src/cda_checker.sv
`default_nettype none

module cda_checker
    import cda_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire res_t result,
    input wire logic result_valid
);

    // An accepted transaction keeps the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without going busy");

    // A result only appears while a transaction is in flight.
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a transaction");

    // Exactly one result cycle per transaction.
    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> (!result_valid && !busy))
        else $error("result strobe longer than one cycle");

    // The compare flag never reports together with a distance or a range error.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.is_earlier && ((result.day_distance != '0)
                           || result.range_error)))
        else $error("conflicting result flags");

endmodule

bind calendar_date_arithmetic_unit cda_checker u_cda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);

`default_nettype wire
